// ===== rtl/bms_pkg.sv =====
// Shared types and constants for the battery mode supervisor.
`timescale 1ns / 1ps
`default_nettype none

package bms_pkg;

	// Battery modes, ordered from lowest to highest bus voltage.
	typedef enum logic [2:0] {
		MODE_HARDOFF  = 3'd0,
		MODE_CRITICAL = 3'd1,
		MODE_SAFE     = 3'd2,
		MODE_NORMAL   = 3'd3,
		MODE_OV       = 3'd4
	} mode_t;

	// Current flow classes.
	typedef enum logic [1:0] {
		CHG_IDLE        = 2'd0,
		CHG_CHARGING    = 2'd1,
		CHG_DISCHARGING = 2'd2
	} charge_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_FULL_V     = 3'd0,
		REG_NORMAL_V   = 3'd1,
		REG_CRITICAL_V = 3'd2,
		REG_HARDOFF_V  = 3'd3,
		REG_HEAT_LOW   = 3'd4,
		REG_HEAT_HIGH  = 3'd5,
		REG_HEAT_AUTO  = 3'd6
	} reg_idx_t;

	localparam int unsigned VOLT_W = 16;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned IN_DATA_W = 64;
	localparam int unsigned OUT_DATA_W = 8;

	// Hysteresis bands, sized for the widened compare.
	localparam logic [VOLT_W:0] VOLT_BAND = 17'd50;
	localparam logic [VOLT_W:0] CURR_BAND = 17'd10;

	// Register values after reset.
	localparam logic [15:0] FULL_V_RST     = 16'd8300;
	localparam logic [15:0] NORMAL_V_RST   = 16'd7200;
	localparam logic [15:0] CRITICAL_V_RST = 16'd6800;
	localparam logic [15:0] HARDOFF_V_RST  = 16'd6200;
	localparam logic signed [15:0] HEAT_LOW_RST  = 16'sd0;
	localparam logic signed [15:0] HEAT_HIGH_RST = 16'sd5;

	typedef struct packed {
		logic [15:0]        full_v;
		logic [15:0]        normal_v;
		logic [15:0]        critical_v;
		logic [15:0]        hardoff_v;
		logic signed [15:0] heat_low;
		logic signed [15:0] heat_high;
		logic               heat_auto;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] battery_temp;
		logic [15:0]        load_current_ma;
		logic [15:0]        charge_current_ma;
		logic [15:0]        bus_voltage_mv;
	} sample_t;

	typedef struct packed {
		logic    heater_on;
		charge_t charge_state;
		logic    mode_changed;
		mode_t   battery_mode;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/bms_cfg_regs.sv =====
// Configuration register file for the battery mode supervisor.
`timescale 1ns / 1ps
`default_nettype none

module bms_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [2:0]                     cfg_index,
	input  wire logic [bms_pkg::CFG_DATA_W-1:0] cfg_data,
	output bms_pkg::cfg_t                       cfg
);
	import bms_pkg::*;

	cfg_t cfg_q;

	// Register writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.full_v     <= FULL_V_RST;
			cfg_q.normal_v   <= NORMAL_V_RST;
			cfg_q.critical_v <= CRITICAL_V_RST;
			cfg_q.hardoff_v  <= HARDOFF_V_RST;
			cfg_q.heat_low   <= HEAT_LOW_RST;
			cfg_q.heat_high  <= HEAT_HIGH_RST;
			cfg_q.heat_auto  <= 1'b0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_FULL_V:     cfg_q.full_v     <= cfg_data;
				REG_NORMAL_V:   cfg_q.normal_v   <= cfg_data;
				REG_CRITICAL_V: cfg_q.critical_v <= cfg_data;
				REG_HARDOFF_V:  cfg_q.hardoff_v  <= cfg_data;
				REG_HEAT_LOW:   cfg_q.heat_low   <= $signed(cfg_data);
				REG_HEAT_HIGH:  cfg_q.heat_high  <= $signed(cfg_data);
				REG_HEAT_AUTO:  cfg_q.heat_auto  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/bms_eval.sv =====
// Per-item evaluation: mode transition, current class and heater thermostat.
`timescale 1ns / 1ps
`default_nettype none

module bms_eval (
	input  wire bms_pkg::sample_t sample,
	input  wire bms_pkg::cfg_t    cfg,
	input  wire bms_pkg::mode_t   mode_cur,
	input  wire logic             heater_cur,
	output bms_pkg::result_t      res
);
	import bms_pkg::*;

	logic [VOLT_W:0] v_w;
	logic [VOLT_W:0] full_w;
	logic [VOLT_W:0] norm_w;
	logic [VOLT_W:0] crit_w;
	logic [VOLT_W:0] hoff_w;
	logic [VOLT_W:0] cin_w;
	logic [VOLT_W:0] cout_w;
	mode_t           mode_nxt;
	charge_t         charge_nxt;
	logic            heater_nxt;

	// Widen everything by one bit so a threshold plus hysteresis never wraps.
	assign v_w    = {1'b0, sample.bus_voltage_mv};
	assign full_w = {1'b0, cfg.full_v};
	assign norm_w = {1'b0, cfg.normal_v};
	assign crit_w = {1'b0, cfg.critical_v};
	assign hoff_w = {1'b0, cfg.hardoff_v};
	assign cin_w  = {1'b0, sample.charge_current_ma};
	assign cout_w = {1'b0, sample.load_current_ma};

	// Mode transitions between adjacent modes. In safe and critical
	// modes the downward test is checked last and wins.
	always_comb begin
		mode_nxt = mode_cur;
		case (mode_cur)
			MODE_OV: begin
				if (v_w < full_w)
					mode_nxt = MODE_NORMAL;
			end
			MODE_NORMAL: begin
				if (v_w > full_w + VOLT_BAND)
					mode_nxt = MODE_OV;
				else if (v_w < norm_w)
					mode_nxt = MODE_SAFE;
			end
			MODE_SAFE: begin
				if (v_w > norm_w + VOLT_BAND)
					mode_nxt = MODE_NORMAL;
				if (v_w < crit_w)
					mode_nxt = MODE_CRITICAL;
			end
			MODE_CRITICAL: begin
				if (v_w > crit_w + VOLT_BAND)
					mode_nxt = MODE_SAFE;
				if (v_w < hoff_w + VOLT_BAND)
					mode_nxt = MODE_HARDOFF;
			end
			MODE_HARDOFF: begin
				if (v_w > hoff_w + VOLT_BAND)
					mode_nxt = MODE_CRITICAL;
			end
			default: mode_nxt = mode_cur;
		endcase
	end

	// Current class with a dead band; the lower test is rearranged to avoid
	// a negative difference.
	always_comb begin
		if (cin_w > cout_w + CURR_BAND)
			charge_nxt = CHG_CHARGING;
		else if (cin_w + CURR_BAND < cout_w)
			charge_nxt = CHG_DISCHARGING;
		else
			charge_nxt = CHG_IDLE;
	end

	// Thermostat; in manual control the heater keeps its state.
	always_comb begin
		heater_nxt = heater_cur;
		if (cfg.heat_auto) begin
			if (!heater_cur) begin
				if ((sample.battery_temp < cfg.heat_low) && (mode_nxt > MODE_CRITICAL))
					heater_nxt = 1'b1;
			end else begin
				if (sample.battery_temp > cfg.heat_high)
					heater_nxt = 1'b0;
			end
		end
	end

	assign res.battery_mode = mode_nxt;
	assign res.mode_changed = (mode_nxt != mode_cur);
	assign res.charge_state = charge_nxt;
	assign res.heater_on    = heater_nxt;

endmodule

`default_nettype wire

// ===== rtl/battery_mode_supervisor.sv =====
// Top level of the battery mode supervisor: stream channels, state and pipeline.
// Usage:
//   The slave channel (s_axis_*) takes one housekeeping sample per item:
//   bus voltage, charge current, load current and battery temperature.
//   The master channel (m_axis_*) returns one status item per sample:
//   battery mode, a mode-changed flag, the current class and heater drive.
//   Thresholds and heater control are written through cfg_we, cfg_index
//   and cfg_data while no sample is in flight.
// Data path:
//   A sample is captured in an input register, evaluated in one pass of
//   compare logic and stored in the result register. One item is accepted
//   every cycle unless m_axis_tready stalls the output.
// Reset:
//   arst_n clears both pipeline stages, loads the register defaults, sets
//   the mode to normal and turns the heater off.
// Stalls:
//   When m_axis_tready is low the result register holds its item and the
//   input register keeps one more; s_axis_tready drops only when both are
//   full. The mode and heater state move only as an item leaves the input
//   register, so stalling never skips or repeats a transition.
`timescale 1ns / 1ps
`default_nettype none

module battery_mode_supervisor (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Input items
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [15:0] bus_voltage_mv, [31:16] charge_current_ma,
	// [47:32] load_current_ma, [63:48] battery_temp
	input  wire logic [bms_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// Result items
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// [2:0] battery_mode, [3] mode_changed, [5:4] charge_state,
	// [6] heater_on, [7] zero
	output logic [bms_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
	// Configuration writes
	input  wire logic                            cfg_we,
	input  wire logic [2:0]                      cfg_index,
	input  wire logic [bms_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bms_pkg::*;

	cfg_t    cfg;
	sample_t sample_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	mode_t   mode_q;
	logic    heater_q;
	result_t res_nxt;
	logic    adv_s2;
	logic    adv_s1;

	bms_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	bms_eval u_eval (
		.sample    (sample_s1),
		.cfg       (cfg),
		.mode_cur  (mode_q),
		.heater_cur(heater_q),
		.res       (res_nxt)
	);

	// Handshake: the result register frees when empty or taken, and the
	// input register frees when empty or moving on.
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = valid_s1 && adv_s2;
	assign s_axis_tready = !valid_s1 || adv_s2;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			sample_s1 <= sample_t'(s_axis_tdata);
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	// Mode and heater state update as an item is evaluated.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NORMAL;
			heater_q <= 1'b0;
		end else if (adv_s1) begin
			mode_q   <= res_nxt.battery_mode;
			heater_q <= res_nxt.heater_on;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {1'b0, res_s2};

endmodule

`default_nettype wire
